>>> rtl/tilt_avg_pkg.sv
`default_nettype none
package tilt_avg_pkg;

  // Store depth and CORDIC iteration count.
  localparam int AVG_DEPTH    = 8;
  localparam int CORDIC_STEPS = 20;

  // Field widths.
  localparam int ACC_W    = 10;
  localparam int PITCH_W  = 18;
  localparam int ROLL_W   = 19;
  localparam int FRAMES_W = 16;

  // Averaging datapath.
  localparam int IDX_W = $clog2(AVG_DEPTH);
  localparam int SUM_W = ACC_W + IDX_W;
  // Reciprocal for the exact truncating divide by the store depth.
  localparam int DIV_K = SUM_W + IDX_W + 1;
  localparam longint RECIP = ((longint'(1) << DIV_K) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam int RECIP_W = DIV_K;

  // Square root: floor(sqrt(s * 2^32)) with s below 2^20.
  localparam int SQ_W   = 2 * ACC_W;
  localparam int ROOT_W = (SQ_W + 32) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;

  // CORDIC datapath.
  localparam int XY_W   = 30;
  localparam int ANG_W  = 34;
  localparam int STEP_W = 5;
  localparam int FRAC_B = 16;

  // Angle conversion: millidegrees per turn, and the clamp limits.
  localparam int MDEG_W     = 19;
  localparam int MDEG_SCALE = 360000;
  localparam int PITCH_LIM  = 90000;
  localparam int ROLL_LIM   = 180000;
  localparam int PROD_W     = ANG_W + MDEG_W;
  localparam int DEG_W      = PROD_W - 32;

  // Request codes.
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  // Top-level sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_MEAN,
    S_SQ,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_PITCH_GO,
    S_PITCH_WAIT,
    S_ROLL_GO,
    S_ROLL_WAIT,
    S_DONE
  } seq_state_t;

  // CORDIC unit states.
  typedef enum logic [1:0] {
    C_IDLE,
    C_ITER,
    C_SCALE,
    C_DONE
  } cordic_state_t;

  // Command into the CORDIC unit.
  typedef struct packed {
    logic start;
    logic is_roll;
  } cordic_ctl_t;

  // Status back from an iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // atan(2^-i) in binary angle units, 2^32 per turn.
  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tilt_avg_if.sv
`default_nettype none
// Request channel: sample words and compute requests.
interface tilt_avg_req_if;
  import tilt_avg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [ACC_W-1:0] accel_x;
  logic signed [ACC_W-1:0] accel_y;
  logic signed [ACC_W-1:0] accel_z;

  modport source (output valid, req_type, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, req_type, accel_x, accel_y, accel_z, output ready);
endinterface

// Result channel: one angle word per compute request.
interface tilt_avg_rsp_if;
  import tilt_avg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [PITCH_W-1:0] pitch_mdeg;
  logic signed [ROLL_W-1:0]  roll_mdeg;
  logic [FRAMES_W-1:0]       frames_seen;

  modport source (output valid, pitch_mdeg, roll_mdeg, frames_seen, input ready);
  modport sink (input valid, pitch_mdeg, roll_mdeg, frames_seen, output ready);
endinterface
`default_nettype wire

>>> rtl/tilt_avg_sqrt.sv
`default_nettype none
module tilt_avg_sqrt (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [tilt_avg_pkg::SQ_W-1:0]    radicand,
  output tilt_avg_pkg::unit_sts_t               sts,
  output logic [tilt_avg_pkg::ROOT_W-1:0]       root
);
  import tilt_avg_pkg::*;

  localparam logic [STEP_W-1:0] LAST = STEP_W'(ROOT_W - 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // One result bit per cycle: bring down two radicand bits and try the subtraction.
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      rad  <= RAD_W'({radicand, 32'b0});
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule
`default_nettype wire

>>> rtl/tilt_avg_cordic.sv
`default_nettype none
module tilt_avg_cordic (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tilt_avg_pkg::cordic_ctl_t           ctl,
  input  wire logic signed [tilt_avg_pkg::XY_W-1:0] vec_y,
  input  wire logic signed [tilt_avg_pkg::XY_W-1:0] vec_x,
  output tilt_avg_pkg::unit_sts_t                  sts,
  output logic signed [tilt_avg_pkg::MDEG_W-1:0]   mdeg
);
  import tilt_avg_pkg::*;

  localparam logic [STEP_W-1:0]   LAST      = STEP_W'(CORDIC_STEPS - 1);
  localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(64'sh40000000);
  localparam logic [DEG_W-1:0]    LIM_PITCH = DEG_W'(PITCH_LIM);
  localparam logic [DEG_W-1:0]    LIM_ROLL  = DEG_W'(ROLL_LIM);

  cordic_state_t state, state_next;

  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic signed [ANG_W-1:0] z;
  logic [STEP_W-1:0]       step;
  logic                    is_roll;
  logic                    zero_vec;
  logic                    neg;
  logic [PROD_W-1:0]       prod;
  logic signed [XY_W-1:0]  xs;
  logic signed [XY_W-1:0]  ys;
  logic signed [ANG_W-1:0] tab;
  logic [ANG_W-1:0]        zmag;
  logic [DEG_W-1:0]        deg;
  logic [DEG_W-1:0]        lim;
  logic [DEG_W-1:0]        deg_clamped;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      C_IDLE:  if (ctl.start) state_next = C_ITER;
      C_ITER:  if (step == LAST) state_next = C_SCALE;
      C_SCALE: state_next = C_DONE;
      C_DONE:  state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared shift-add step and angle table lookup.
  assign xs   = x >>> step;
  assign ys   = y >>> step;
  assign tab  = ANG_W'(atan_entry(step));
  assign zmag = z[ANG_W-1] ? ANG_W'(-z) : ANG_W'(z);

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (ctl.start) begin
          step     <= '0;
          is_roll  <= ctl.is_roll;
          zero_vec <= (vec_x == '0) && (vec_y == '0);
          // Left half plane: pre-rotate by a quarter turn towards the right.
          if (vec_x[XY_W-1]) begin
            if (!vec_y[XY_W-1]) begin
              x <= vec_y;
              y <= -vec_x;
              z <= QUARTER;
            end else begin
              x <= -vec_y;
              y <= vec_x;
              z <= -QUARTER;
            end
          end else begin
            x <= vec_x;
            y <= vec_y;
            z <= '0;
          end
        end
      end
      C_ITER: begin
        step <= step + 1'b1;
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + tab;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - tab;
        end
      end
      C_SCALE: begin
        // Scale the angle magnitude to millidegrees per turn; a zero vector gives zero.
        neg  <= z[ANG_W-1] && !zero_vec;
        prod <= zero_vec ? '0 : PROD_W'(zmag) * PROD_W'(MDEG_SCALE);
      end
      default: begin
      end
    endcase
  end

  // Truncate, clamp to the range of the angle and restore the sign.
  assign deg         = prod[PROD_W-1 -: DEG_W];
  assign lim         = is_roll ? LIM_ROLL : LIM_PITCH;
  assign deg_clamped = (deg > lim) ? lim : deg;

  // Outputs.
  always_comb begin
    sts.busy = (state != C_IDLE);
    sts.done = (state == C_DONE);
    mdeg     = neg ? -MDEG_W'(deg_clamped) : MDEG_W'(deg_clamped);
  end

endmodule
`default_nettype wire

>>> rtl/accel_tilt_averager_unit.sv
`default_nettype none
// Channel  Dir  Handshake     Word
// req      in   valid/ready   req_type, accel_x, accel_y, accel_z
// rsp      out  valid/ready   pitch_mdeg, roll_mdeg, frames_seen
//
// A sample word is taken in a single handshake; the block is ready again straight away.
// A compute request runs a summing sweep over the store, the bit-serial square root
// and the shared CORDIC unit, used for pitch then roll. req.ready is low for the
// whole of a compute request.
// Reset clears the sample store, slot pointer and frame counter.
// A finished result waits in the output register; a stalled rsp only holds
// the block once the next result is ready to be loaded.
module accel_tilt_averager_unit (
  input wire logic     clk,
  input wire logic     rst,
  tilt_avg_req_if.sink   req,
  tilt_avg_rsp_if.source rsp
);
  import tilt_avg_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_DEPTH - 1);

  seq_state_t state, state_next;

  logic signed [ACC_W-1:0] store_x [AVG_DEPTH];
  logic signed [ACC_W-1:0] store_y [AVG_DEPTH];
  logic signed [ACC_W-1:0] store_z [AVG_DEPTH];
  logic [IDX_W-1:0]        write_slot;
  logic [FRAMES_W-1:0]     frame_counter;

  logic [IDX_W-1:0]        rd_idx;
  logic [1:0]              axis;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] sum_z;
  logic signed [ACC_W-1:0] mean_x;
  logic signed [ACC_W-1:0] mean_y;
  logic signed [ACC_W-1:0] mean_z;
  logic [SQ_W-1:0]         sq_acc;
  logic signed [PITCH_W-1:0] pitch;
  logic signed [ROLL_W-1:0]  roll;

  logic                         req_acc;
  logic signed [SUM_W-1:0]      sel_sum;
  logic [SUM_W-1:0]             sum_abs;
  logic [SUM_W+RECIP_W-1:0]     div_prod;
  logic [ACC_W-1:0]             quot;
  logic signed [ACC_W-1:0]      mean_new;
  logic signed [ACC_W-1:0]      sq_in;
  logic signed [SQ_W-1:0]       sq;
  logic                         sqrt_start;
  unit_sts_t                    sqrt_sts;
  logic [ROOT_W-1:0]            root;
  cordic_ctl_t                  cordic_ctl;
  unit_sts_t                    cordic_sts;
  logic signed [XY_W-1:0]       vec_y;
  logic signed [XY_W-1:0]       vec_x;
  logic signed [MDEG_W-1:0]     mdeg;
  logic                         out_load;

  assign req_acc = req.valid && req.ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (req_acc && req.req_type == REQ_COMPUTE) state_next = S_SUM;
      S_SUM:        if (rd_idx == IDX_LAST) state_next = S_MEAN;
      S_MEAN:       if (axis == 2'd2) state_next = S_SQ;
      S_SQ:         if (axis == 2'd1) state_next = S_SQRT_GO;
      S_SQRT_GO:    state_next = S_SQRT_WAIT;
      S_SQRT_WAIT:  if (sqrt_sts.done) state_next = S_PITCH_GO;
      S_PITCH_GO:   state_next = S_PITCH_WAIT;
      S_PITCH_WAIT: if (cordic_sts.done) state_next = S_ROLL_GO;
      S_ROLL_GO:    state_next = S_ROLL_WAIT;
      S_ROLL_WAIT:  if (cordic_sts.done) state_next = S_DONE;
      S_DONE:       if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req.ready          = (state == S_IDLE);
    sqrt_start         = (state == S_SQRT_GO);
    cordic_ctl.start   = (state == S_PITCH_GO) || (state == S_ROLL_GO);
    cordic_ctl.is_roll = (state == S_ROLL_GO);
    out_load           = (state == S_DONE) && (!rsp.valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sample store, slot pointer and frame counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        store_x[i] <= '0;
        store_y[i] <= '0;
        store_z[i] <= '0;
      end
      write_slot    <= '0;
      frame_counter <= '0;
    end else if (req_acc && req.req_type == REQ_SAMPLE) begin
      store_x[write_slot] <= req.accel_x;
      store_y[write_slot] <= req.accel_y;
      store_z[write_slot] <= req.accel_z;
      write_slot    <= (write_slot == IDX_LAST) ? '0 : write_slot + 1'b1;
      frame_counter <= frame_counter + 1'b1;
    end
  end

  // Truncating mean by multiplying with the rounded-up reciprocal of the depth.
  always_comb begin
    case (axis)
      2'd0:    sel_sum = sum_x;
      2'd1:    sel_sum = sum_y;
      default: sel_sum = sum_z;
    endcase
    sum_abs  = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
    div_prod = (SUM_W+RECIP_W)'(sum_abs) * (SUM_W+RECIP_W)'(RECIP);
    quot     = div_prod[DIV_K +: ACC_W];
    mean_new = sel_sum[SUM_W-1] ? -ACC_W'(quot) : ACC_W'(quot);
    sq_in    = (axis == 2'd0) ? mean_x : mean_z;
    sq       = sq_in * sq_in;
  end

  // Averaging and squaring datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rd_idx <= '0;
        axis   <= '0;
        sum_x  <= '0;
        sum_y  <= '0;
        sum_z  <= '0;
      end
      S_SUM: begin
        sum_x  <= sum_x + SUM_W'(store_x[rd_idx]);
        sum_y  <= sum_y + SUM_W'(store_y[rd_idx]);
        sum_z  <= sum_z + SUM_W'(store_z[rd_idx]);
        rd_idx <= rd_idx + 1'b1;
      end
      S_MEAN: begin
        case (axis)
          2'd0:    mean_x <= mean_new;
          2'd1:    mean_y <= mean_new;
          default: mean_z <= mean_new;
        endcase
        axis <= (axis == 2'd2) ? 2'd0 : axis + 1'b1;
      end
      S_SQ: begin
        sq_acc <= (axis == 2'd0) ? SQ_W'(sq) : sq_acc + SQ_W'(sq);
        axis   <= axis + 1'b1;
      end
      S_PITCH_WAIT: begin
        if (cordic_sts.done) pitch <= PITCH_W'(mdeg);
      end
      S_ROLL_WAIT: begin
        if (cordic_sts.done) roll <= ROLL_W'(mdeg);
      end
      default: begin
      end
    endcase
  end

  // Operands of the shared CORDIC unit: pitch first, then roll.
  always_comb begin
    if (state == S_ROLL_GO) begin
      vec_y = -(XY_W'(mean_x) <<< FRAC_B);
      vec_x = XY_W'(mean_z) <<< FRAC_B;
    end else begin
      vec_y = XY_W'(mean_y) <<< FRAC_B;
      vec_x = XY_W'(root);
    end
  end

  tilt_avg_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq_acc),
    .sts      (sqrt_sts),
    .root     (root)
  );

  tilt_avg_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cordic_ctl),
    .vec_y (vec_y),
    .vec_x (vec_x),
    .sts   (cordic_sts),
    .mdeg  (mdeg)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.pitch_mdeg  <= pitch;
      rsp.roll_mdeg   <= roll;
      rsp.frames_seen <= frame_counter;
    end
  end

  // A compute request starts the summing sweep.
  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    req_acc && req.req_type == REQ_COMPUTE |=> state == S_SUM)
    else $error("compute request did not start the summing sweep");

  // Each sample word advances the frame counter by one.
  a_frame_count: assert property (@(posedge clk) disable iff (rst)
    req_acc && req.req_type == REQ_SAMPLE |=>
      frame_counter == $past(frame_counter) + 1'b1)
    else $error("frame counter did not advance on a sample word");

  // The store pointer does not move while a request is being worked on.
  a_store_frozen: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> $stable(write_slot) && $stable(frame_counter))
    else $error("store changed during a compute request");

  // A new result is only loaded from the final sequencer state.
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_DONE)
    else $error("result appeared outside the final state");

  // The shared CORDIC unit is only started when it is free.
  a_cordic_free: assert property (@(posedge clk) disable iff (rst)
    cordic_ctl.start |-> !cordic_sts.busy)
    else $error("CORDIC started while busy");

endmodule
`default_nettype wire
